/* design/mavt_pkg.sv */
// ----------------------------------------------------------------------------
// mavt_pkg
// Shared types and constants of the multiturn angle and velocity tracker:
// item kinds, controller states, command and status bundles, fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mavt_pkg;

    // item kinds carried on s_tuser
    localparam logic [2:0] KIND_START    = 3'd0;
    localparam logic [2:0] KIND_ANGLE    = 3'd1;
    localparam logic [2:0] KIND_VELOCITY = 3'd2;
    localparam logic [2:0] KIND_REL_ZERO = 3'd3;
    localparam logic [2:0] KIND_ABS_ZERO = 3'd4;

    // fixed field widths
    localparam int KIND_W   = 3;
    localparam int WORD_W   = 16;
    localparam int TIME_W   = 32;
    localparam int ANGLE_W  = 47;
    localparam int VEL_W    = 32;
    localparam int RES_W    = 4;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 128;

    // resolution register reset value
    localparam logic [RES_W-1:0] RES_RESET = 4'd14;

    // time step handling
    localparam int               DT_W       = 19;
    localparam logic [TIME_W-1:0] DT_MAX    = 32'd500000;
    localparam logic [DT_W-1:0]  DT_DEFAULT = 19'd1000;

    // velocity scaling: numerator = |delta angle| * 1e6, quotient below 2^31
    localparam int              MICRO_W     = 20;
    localparam logic [MICRO_W-1:0] MICRO_PER_S = 20'd1000000;
    localparam int              MAG_LO_W    = 24;
    localparam int              MAG_HI_W    = ANGLE_W - MAG_LO_W;
    localparam int              NUM_W       = 67;
    localparam int              DIV_STEPS   = 31;
    localparam int              CNT_W       = $clog2(DIV_STEPS);

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TURN,
        ST_ANGLE,
        ST_APPLY,
        ST_ABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SAT,
        ST_DIV,
        ST_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic turn;
        logic angle;
        logic apply;
        logic abs_diff;
        logic mul_lo;
        logic mul_hi;
        logic sat;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_vel;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* design/mavt_ctrl.sv */
// ----------------------------------------------------------------------------
// mavt_ctrl
// Sequencer for one item: tracking steps, then for velocity reads the
// scaling multiply and the restoring divide, then the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mavt_ctrl
    import mavt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TURN;
                end
            end
            ST_TURN:
            begin
                cmd.turn   = 1'b1;
                state_next = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                cmd.angle  = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = status.is_vel ? ST_ABS : ST_DONE;
            end
            ST_ABS:
            begin
                cmd.abs_diff = 1'b1;
                state_next   = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/mavt_datapath.sv */
// ----------------------------------------------------------------------------
// mavt_datapath
// Tracking state, unwrapped angle arithmetic, velocity scaling and division,
// resolution register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mavt_datapath
    import mavt_pkg::*;
#(
    parameter int RAW_BITS  = 14,
    parameter int TURN_BITS = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    input  wire logic [IN_W-1:0]   in_data,
    input  wire logic [KIND_W-1:0] in_kind,
    input  wire logic              cfg_wr_en,
    input  wire logic [RES_W-1:0]  cfg_wr_data,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata
);

    localparam int CMP_W = RAW_BITS + 4;
    localparam int HI_W  = NUM_W - DIV_STEPS;

    // architectural state
    logic [RES_W-1:0]     res_reg;
    logic [TURN_BITS-1:0] turn_reg;
    logic [RAW_BITS-1:0]  last_raw_reg;
    logic [RAW_BITS-1:0]  zero_reg;
    logic [ANGLE_W-1:0]   last_vel_angle_reg;
    logic [TIME_W-1:0]    last_vel_time_reg;
    logic                 m_valid_reg;

    // item payload and working registers
    logic [KIND_W-1:0]    kind_reg;
    logic [RAW_BITS-1:0]  raw_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [DT_W-1:0]      dt_reg;
    logic [ANGLE_W-1:0]   angle_reg;
    logic [ANGLE_W-1:0]   shift_reg;
    logic [ANGLE_W:0]     diff_reg;
    logic                 neg_reg;
    logic [ANGLE_W-1:0]   mag_reg;
    logic [NUM_W-1:0]     num_reg;
    logic                 sat_reg;
    logic [DT_W-1:0]      rem_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    // effective resolution clamped into 1..RAW_BITS
    logic [RES_W-1:0]     res_eff;
    always_comb
    begin
        if (res_reg == '0)
            res_eff = RES_W'(1);
        else if (res_reg > RES_W'(RAW_BITS))
            res_eff = RES_W'(RAW_BITS);
        else
            res_eff = res_reg;
    end

    // wrap detection: 5 * |raw - last| > 4 * cpr
    logic [RAW_BITS:0]    raw_diff;
    logic [RAW_BITS:0]    raw_mag;
    logic [CMP_W-1:0]     mag_x5;
    logic [CMP_W-1:0]     cpr_x4;
    logic                 wrap;
    always_comb
    begin
        raw_diff = {1'b0, raw_reg} - {1'b0, last_raw_reg};
        raw_mag  = raw_diff[RAW_BITS] ? (~raw_diff + 1'b1) : raw_diff;
        mag_x5   = (CMP_W'(raw_mag) << 2) + CMP_W'(raw_mag);
        cpr_x4   = CMP_W'(4) << res_eff;
        wrap     = mag_x5 > cpr_x4;
    end

    // time step since last velocity read, with fallback
    logic [TIME_W-1:0]    dt_raw;
    logic [DT_W-1:0]      dt_calc;
    always_comb
    begin
        dt_raw = time_reg - last_vel_time_reg;
        if (dt_raw == '0 || dt_raw > DT_MAX)
            dt_calc = DT_DEFAULT;
        else
            dt_calc = dt_raw[DT_W-1:0];
    end

    // unwrapped angle: turns * cpr + raw - zero
    logic [ANGLE_W-1:0]   turn_ext;
    logic [ANGLE_W-1:0]   angle_calc;
    always_comb
    begin
        turn_ext   = {{(ANGLE_W-TURN_BITS){turn_reg[TURN_BITS-1]}}, turn_reg};
        angle_calc = (turn_ext << res_eff) + ANGLE_W'(raw_reg) - ANGLE_W'(zero_reg);
    end

    // scaling partial products by one million
    logic [MAG_LO_W+MICRO_W-1:0] prod_lo;
    logic [MAG_HI_W+MICRO_W-1:0] prod_hi;
    always_comb
    begin
        prod_lo = mag_reg[MAG_LO_W-1:0] * MICRO_PER_S;
        prod_hi = mag_reg[ANGLE_W-1:MAG_LO_W] * MICRO_PER_S;
    end

    // one restoring division step
    logic [DT_W:0]        trial;
    logic                 trial_ge;
    always_comb
    begin
        trial    = {rem_reg, num_reg[DIV_STEPS-1]};
        trial_ge = trial >= {1'b0, dt_reg};
    end

    // saturated signed velocity
    logic [VEL_W-1:0]     vel_calc;
    always_comb
    begin
        if (sat_reg)
            vel_calc = neg_reg ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        else if (neg_reg)
            vel_calc = ~{1'b0, quo_reg} + 1'b1;
        else
            vel_calc = {1'b0, quo_reg};
    end

    // result fields gated by kind
    logic [ANGLE_W-1:0]   angle_out;
    logic [VEL_W-1:0]     vel_out;
    logic [ANGLE_W-1:0]   shift_out;
    always_comb
    begin
        angle_out = '0;
        vel_out   = '0;
        shift_out = '0;
        case (kind_reg)
            KIND_ANGLE:
            begin
                angle_out = angle_reg;
            end
            KIND_VELOCITY:
            begin
                angle_out = angle_reg;
                vel_out   = vel_calc;
            end
            KIND_REL_ZERO:
            begin
                angle_out = angle_reg;
                shift_out = shift_reg;
            end
            KIND_ABS_ZERO:
            begin
                shift_out = shift_reg;
            end
            default:
            begin
                angle_out = '0;
            end
        endcase
    end

    // tracking state, resolution register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg            <= RES_RESET;
            turn_reg           <= '0;
            last_raw_reg       <= '0;
            zero_reg           <= '0;
            last_vel_angle_reg <= '0;
            last_vel_time_reg  <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                res_reg <= cfg_wr_data;
            end
            if (cmd.turn)
            begin
                case (kind_reg)
                    KIND_START:
                    begin
                        turn_reg           <= '0;
                        zero_reg           <= '0;
                        last_raw_reg       <= raw_reg;
                        last_vel_angle_reg <= '0;
                        last_vel_time_reg  <= time_reg;
                    end
                    KIND_ANGLE, KIND_VELOCITY, KIND_REL_ZERO:
                    begin
                        last_raw_reg <= raw_reg;
                        if (wrap)
                        begin
                            // positive jump means a backward wrap
                            if (raw_diff[RAW_BITS])
                                turn_reg <= turn_reg + 1'b1;
                            else
                                turn_reg <= turn_reg - 1'b1;
                        end
                    end
                    KIND_ABS_ZERO:
                    begin
                        turn_reg <= '0;
                        zero_reg <= '0;
                    end
                    default:
                    begin
                        turn_reg <= turn_reg;
                    end
                endcase
            end
            if (cmd.apply)
            begin
                case (kind_reg)
                    KIND_VELOCITY:
                    begin
                        last_vel_angle_reg <= angle_reg;
                        last_vel_time_reg  <= time_reg;
                    end
                    KIND_REL_ZERO:
                    begin
                        zero_reg <= raw_reg;
                        turn_reg <= '0;
                    end
                    default:
                    begin
                        zero_reg <= zero_reg;
                    end
                endcase
            end
            // output transaction bookkeeping
            if (cmd.out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            raw_reg  <= in_data[RAW_BITS-1:0];
            time_reg <= in_data[WORD_W+TIME_W-1:WORD_W];
        end
        if (cmd.turn)
        begin
            dt_reg    <= dt_calc;
            shift_reg <= ~ANGLE_W'(zero_reg) + 1'b1;
        end
        if (cmd.angle)
        begin
            angle_reg <= angle_calc;
        end
        if (cmd.apply)
        begin
            diff_reg <= {angle_reg[ANGLE_W-1], angle_reg}
                      - {last_vel_angle_reg[ANGLE_W-1], last_vel_angle_reg};
            if (kind_reg == KIND_REL_ZERO)
                shift_reg <= ~angle_reg + 1'b1;
        end
        if (cmd.abs_diff)
        begin
            neg_reg <= diff_reg[ANGLE_W];
            mag_reg <= diff_reg[ANGLE_W] ? ANGLE_W'(~diff_reg + 1'b1) : diff_reg[ANGLE_W-1:0];
        end
        if (cmd.mul_lo)
        begin
            num_reg <= NUM_W'(prod_lo);
        end
        if (cmd.mul_hi)
        begin
            num_reg <= num_reg + (NUM_W'(prod_hi) << MAG_LO_W);
        end
        if (cmd.sat)
        begin
            // quotient of 2^31 or more saturates
            sat_reg <= num_reg[NUM_W-1:DIV_STEPS] >= HI_W'(dt_reg);
            rem_reg <= num_reg[DIV_STEPS+DT_W-1:DIV_STEPS];
        end
        if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_STEPS-2:0], trial_ge};
            rem_reg <= trial_ge ? DT_W'(trial - {1'b0, dt_reg}) : trial[DT_W-1:0];
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {2'b00, shift_out, vel_out, angle_out};
        end
    end

    assign status.is_vel   = (kind_reg == KIND_VELOCITY);
    assign status.out_free = !m_valid_reg || m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

`default_nettype wire

/* design/multiturn_angle_velocity_tracker_core.sv */
// ----------------------------------------------------------------------------
// multiturn_angle_velocity_tracker_core
// Multiturn angle unwrap of a magnetic encoder read stream, with zeroing
// and a velocity estimate in counts per second.
// ----------------------------------------------------------------------------
// Each input transaction carries a sensor response word and a microsecond
// timestamp, with the item kind on s_tuser (start, angle read, velocity read,
// relative zero, absolute zero). One result transaction follows every input.
// Items are handled one at a time: start, angle and zero items pass through
// the turn, angle and apply steps before the result register is loaded, and
// velocity reads add the scaling multiply and the 31-step restoring divider
// that divides the scaled angle change by the time step. The result register
// is loaded once the output register is free, and the next item is accepted
// in the cycle after that. A finished result waits in the output register
// while the next item is accepted. The resolution register (counts per
// revolution = 2^resolution) should be written only while no item is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module multiturn_angle_velocity_tracker_core
    import mavt_pkg::*;
#(
    parameter int RAW_BITS  = 14,
    parameter int TURN_BITS = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // resolution register write
    input  wire logic              cfg_wr_en,
    input  wire logic [RES_W-1:0]  cfg_wr_data,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // raw_word[15:0], time_us[47:16]
    input  wire logic [KIND_W-1:0] s_tuser,   // kind[2:0]
    // output stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata    // angle_counts[46:0],
                                              // velocity_counts_per_s[78:47],
                                              // zero_shift_counts[125:79], zero pad
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    mavt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    mavt_datapath #(
        .RAW_BITS  (RAW_BITS),
        .TURN_BITS (TURN_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_data     (s_tdata),
        .in_kind     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire
